// File: hdl/zrcoef_pkg.sv
// Shared constants and the Exp-Golomb length helper for the zero-run coefficient encoder.
package zrcoef_pkg;

    // Width of the value coded by one Exp-Golomb codeword (v + 1 <= 65535 fits in 17 bits).
    localparam int unsigned EG_IN_W = 17;

    // Largest magnitude minus one that is coded, so that every codeword fits in 32 bits.
    localparam logic [15:0] MAG_LIMIT = 16'hFFFE;

    // Width of the code_bits and code_length result fields.
    localparam int unsigned CODE_W = 32;
    localparam int unsigned LEN_W  = 6;

    // Number of result slots one input beat can produce.
    localparam int unsigned SLOT_N = 3;

    // One result beat.
    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  length;
        logic              done;
    } result_t;

    // Length of the order-0 Exp-Golomb code for x = v + 1: 2 * floor(log2(x)) + 1.
    function automatic logic [LEN_W-1:0] eg_length(input logic [EG_IN_W-1:0] x);
        logic [4:0] msb;
        msb = 5'd0;
        for (int i = 0; i < EG_IN_W; i++) begin
            if (x[i]) begin
                msb = 5'(i);
            end
        end
        return {msb, 1'b1};
    endfunction

endpackage

// File: hdl/zero_run_exp_golomb_coeff_encoder.sv
// Top level of the zero-run / Exp-Golomb coefficient encoder.
//
// Usage:
//   Coefficients of one block enter on the coeff channel (coefficient, end_of_block),
//   highest index first; end_of_block marks index zero. A beat moves when coeff_valid
//   is high and coeff_stall is low. Codewords leave on the code channel (code_bits,
//   code_length, block_done) under code_valid / code_stall, one codeword per beat.
//   A nonzero coefficient gives a zero-run code and a magnitude code. The closing beat
//   adds any pending run code and then the sign buffer beat with block_done set.
//   Each taken beat waits in the input register and hands its codewords in turn to
//   the output register. A zero coefficient that does not close the block gives no
//   codeword; any other beat gives one or more (two for a nonzero coefficient, at
//   most three); the single output register carries one codeword per cycle unless stalled.
//   A new beat is taken in the same cycle as the last codeword of the previous one.
//   When the receiver stalls, the output register holds its codeword and the held
//   input beat back-pressures the sender through coeff_stall.
//   Reset (rst_n low) empties both registers and clears the run and sign state.
module zero_run_exp_golomb_coeff_encoder #(
    parameter int unsigned BLOCK_SIZE = 16,
    parameter int unsigned COEFF_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   coeff_valid,
    output logic                                   coeff_stall,
    input  logic signed [COEFF_BITS-1:0]           coefficient,
    input  logic                                   end_of_block,
    output logic                                   code_valid,
    input  logic                                   code_stall,
    output logic [zrcoef_pkg::CODE_W-1:0]          code_bits,
    output logic [zrcoef_pkg::LEN_W-1:0]           code_length,
    output logic                                   block_done
);

    localparam int unsigned RUN_W = $clog2(BLOCK_SIZE + 1);
    localparam int unsigned VM_W  = (COEFF_BITS > 16) ? COEFF_BITS : 17;

    // Input register.
    logic                       item_valid_reg, item_valid_next;
    logic [COEFF_BITS-1:0]      coeff_reg;
    logic                       eob_reg;

    // Result slot index within the held beat.
    logic [1:0]                 idx_reg, idx_next;

    // Block state.
    logic [RUN_W-1:0]           zero_run_reg, zero_run_next;
    logic [BLOCK_SIZE-1:0]      sign_bits_reg, sign_bits_next;
    logic [RUN_W-1:0]           sign_count_reg, sign_count_next;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    zrcoef_pkg::result_t        out_reg;

    // Decode of the held beat.
    logic                       is_zero;
    logic                       negative;
    logic [RUN_W-1:0]           run_inc;
    logic [RUN_W-1:0]           run_val;
    logic [COEFF_BITS-1:0]      vm_raw;
    logic [VM_W-1:0]            vm_ext;
    logic [15:0]                vm_sat;
    logic [zrcoef_pkg::EG_IN_W-1:0] run_x;
    logic [zrcoef_pkg::EG_IN_W-1:0] mag_x;
    logic [BLOCK_SIZE-1:0]      sign_upd;
    logic [RUN_W-1:0]           count_upd;
    zrcoef_pkg::result_t        run_res, mag_res, sign_res, sel_res;
    logic [1:0]                 res_count;

    // Handshake control.
    logic                       accept;
    logic                       load_out;
    logic                       retire;

    // Coefficient decode: magnitude minus one is ~raw for negatives, raw - 1 otherwise.
    always_comb
    begin
        is_zero  = (coeff_reg == '0);
        negative = coeff_reg[COEFF_BITS-1];
        run_inc  = (zero_run_reg < RUN_W'(BLOCK_SIZE)) ? zero_run_reg + RUN_W'(1) : zero_run_reg;
        run_val  = is_zero ? run_inc : zero_run_reg;
        vm_raw   = negative ? ~coeff_reg : coeff_reg - COEFF_BITS'(1);
        vm_ext   = VM_W'(vm_raw);
        vm_sat   = (vm_ext > VM_W'(zrcoef_pkg::MAG_LIMIT)) ? zrcoef_pkg::MAG_LIMIT : vm_ext[15:0];
        run_x    = zrcoef_pkg::EG_IN_W'(run_val) + zrcoef_pkg::EG_IN_W'(1);
        mag_x    = zrcoef_pkg::EG_IN_W'(vm_sat) + zrcoef_pkg::EG_IN_W'(1);
    end

    // Sign buffer after this beat; signs beyond the block size are dropped.
    always_comb
    begin
        sign_upd  = sign_bits_reg;
        count_upd = sign_count_reg;
        if (!is_zero && (sign_count_reg < RUN_W'(BLOCK_SIZE))) begin
            sign_upd  = (sign_bits_reg << 1) | BLOCK_SIZE'(!negative);
            count_upd = sign_count_reg + RUN_W'(1);
        end
    end

    // The three possible codewords and the one picked by the slot index.
    always_comb
    begin
        run_res.bits    = zrcoef_pkg::CODE_W'(run_x);
        run_res.length  = zrcoef_pkg::eg_length(run_x);
        run_res.done    = 1'b0;
        mag_res.bits    = zrcoef_pkg::CODE_W'(mag_x);
        mag_res.length  = zrcoef_pkg::eg_length(mag_x);
        mag_res.done    = 1'b0;
        sign_res.bits   = zrcoef_pkg::CODE_W'(sign_upd);
        sign_res.length = zrcoef_pkg::LEN_W'(count_upd);
        sign_res.done   = 1'b1;

        if (is_zero) begin
            res_count = eob_reg ? 2'd2 : 2'd0;
            sel_res   = (idx_reg == 2'd0) ? run_res : sign_res;
        end else begin
            res_count = eob_reg ? 2'd3 : 2'd2;
            case (idx_reg)
                2'd0:    sel_res = run_res;
                2'd1:    sel_res = mag_res;
                default: sel_res = sign_res;
            endcase
        end
    end

    // Handshake: the held beat retires when its last codeword moves to the output register, or at once if it has none.
    always_comb
    begin
        load_out = item_valid_reg && (res_count != 2'd0) && (!out_valid_reg || !code_stall);
        retire   = item_valid_reg &&
                   ((res_count == 2'd0) || (load_out && (idx_reg == res_count - 2'd1)));
        coeff_stall = item_valid_reg && !retire;
        accept      = coeff_valid && !coeff_stall;
    end

    // Next-state logic for control and block state.
    always_comb
    begin
        item_valid_next = accept ? 1'b1 : (retire ? 1'b0 : item_valid_reg);
        idx_next        = idx_reg;
        if (retire) begin
            idx_next = 2'd0;
        end else if (load_out) begin
            idx_next = idx_reg + 2'd1;
        end

        out_valid_next = load_out ? 1'b1 : (code_stall ? out_valid_reg : 1'b0);

        zero_run_next   = zero_run_reg;
        sign_bits_next  = sign_bits_reg;
        sign_count_next = sign_count_reg;
        if (retire) begin
            if (eob_reg) begin
                zero_run_next   = '0;
                sign_bits_next  = '0;
                sign_count_next = '0;
            end else begin
                zero_run_next   = is_zero ? run_inc : '0;
                sign_bits_next  = sign_upd;
                sign_count_next = count_upd;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
            out_valid_reg  <= 1'b0;
            zero_run_reg   <= '0;
            sign_bits_reg  <= '0;
            sign_count_reg <= '0;
        end else begin
            item_valid_reg <= item_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            zero_run_reg   <= zero_run_next;
            sign_bits_reg  <= sign_bits_next;
            sign_count_reg <= sign_count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            coeff_reg <= coefficient;
            eob_reg   <= end_of_block;
        end
        if (load_out) begin
            out_reg <= sel_res;
        end
    end

    assign code_valid  = out_valid_reg;
    assign code_bits   = out_reg.bits;
    assign code_length = out_reg.length;
    assign block_done  = out_reg.done;

`ifndef ASSERT_OFF
    // Run and sign counters never pass the block size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (zero_run_reg <= RUN_W'(BLOCK_SIZE)) && (sign_count_reg <= RUN_W'(BLOCK_SIZE)))
        else $error("run or sign count beyond block size");

    // The slot index stays inside the codewords of the held beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && (res_count != 2'd0) |-> idx_reg < res_count)
        else $error("slot index past last codeword");

    // Exp-Golomb codewords always have odd length.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !block_done |-> code_length[0])
        else $error("even Exp-Golomb length");

    // The sign beat never carries more signs than the block holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && block_done |-> code_length <= zrcoef_pkg::LEN_W'(BLOCK_SIZE))
        else $error("sign beat too long");

    // A closing beat resets the block state once it retires.
    assert property (@(posedge clk) disable iff (!rst_n)
        retire && eob_reg |=> (zero_run_reg == '0) && (sign_count_reg == '0))
        else $error("block state not cleared after closing beat");
`endif

endmodule

// File: verif/tb_zero_run_exp_golomb_coeff_encoder.sv
// Self-checking testbench for the zero-run / Exp-Golomb coefficient encoder.
`timescale 1ns / 100ps

module tb_zero_run_exp_golomb_coeff_encoder;

    localparam int unsigned BLOCK_SIZE   = 16;
    localparam int unsigned COEFF_BITS   = 16;
    localparam int          IDLE_PCT     = 19;
    localparam int          RANDOM_ITEMS = 110;
    localparam int          DRAIN_CYCLES = 10;

    logic                              clk;
    logic                              rst_n;
    logic                              coeff_valid;
    logic                              coeff_stall;
    logic [COEFF_BITS-1:0]             coefficient;
    logic                              end_of_block;
    logic                              code_valid;
    logic                              code_stall;
    logic [zrcoef_pkg::CODE_W-1:0]     code_bits;
    logic [zrcoef_pkg::LEN_W-1:0]      code_length;
    logic                              block_done;

    // Codewords still owed by the encoder, oldest first.
    zrcoef_pkg::result_t expected_codes[$];

    // Shadow copy of the encoder state.
    logic [4:0]  run_len;
    logic [15:0] sign_buf;
    logic [4:0]  sign_cnt;

    int err_count = 0;
    int gap_pct;

    zero_run_exp_golomb_coeff_encoder #(
        .BLOCK_SIZE(BLOCK_SIZE),
        .COEFF_BITS(COEFF_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .coeff_valid(coeff_valid),
        .coeff_stall(coeff_stall),
        .coefficient(coefficient),
        .end_of_block(end_of_block),
        .code_valid(code_valid),
        .code_stall(code_stall),
        .code_bits(code_bits),
        .code_length(code_length),
        .block_done(block_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run ends here if the encoder hangs.
    initial
    begin
        #(2_000_000);
        $display("tb: failure");
        $finish;
    end

    // Queue the order-0 Exp-Golomb codeword of v: v + 1 in 2n + 1 bits.
    function automatic void queue_golomb(input int unsigned v);
        int unsigned         x;
        int unsigned         n;
        zrcoef_pkg::result_t w;
        x = v + 1;
        n = 0;
        while ((x >> (n + 1)) != 0)
        begin
            n++;
        end
        w.bits   = x;
        w.length = 6'(2 * n + 1);
        w.done   = 1'b0;
        expected_codes.push_back(w);
    endfunction

    // Work out the codewords caused by one accepted coefficient beat.
    function automatic void predict_codes(input logic [15:0] c, input logic eob);
        logic [16:0]         mag;
        logic [16:0]         mag_m1;
        zrcoef_pkg::result_t w;
        if (c == 16'd0)
        begin
            if (run_len < BLOCK_SIZE)
            begin
                run_len = run_len + 5'd1;
            end
            if (eob && run_len != 5'd0)
            begin
                queue_golomb(run_len);
            end
        end
        else
        begin
            mag    = c[15] ? (17'h10000 - {1'b0, c}) : {1'b0, c};
            mag_m1 = mag - 17'd1;
            if (mag_m1 > {1'b0, zrcoef_pkg::MAG_LIMIT})
            begin
                mag_m1 = {1'b0, zrcoef_pkg::MAG_LIMIT};
            end
            queue_golomb(run_len);
            run_len = '0;
            // Signs past the buffer size are dropped; 1 means positive.
            if (sign_cnt < BLOCK_SIZE)
            begin
                sign_buf = {sign_buf[14:0], ~c[15]};
                sign_cnt = sign_cnt + 5'd1;
            end
            queue_golomb(mag_m1);
        end
        // The closing beat sends the sign buffer and clears all state.
        if (eob)
        begin
            w.bits   = {16'd0, sign_buf} & ((32'd1 << sign_cnt) - 32'd1);
            w.length = 6'(sign_cnt);
            w.done   = 1'b1;
            expected_codes.push_back(w);
            run_len  = '0;
            sign_buf = '0;
            sign_cnt = '0;
        end
    endfunction

    // Send one coefficient beat, with a random idle gap first.
    task automatic send_coeff(input logic [15:0] c, input logic eob);
        logic taken;
        while ($urandom_range(99) < gap_pct)
        begin
            coeff_valid <= 1'b0;
            @(posedge clk);
        end
        coeff_valid  <= 1'b1;
        coefficient  <= c;
        end_of_block <= eob;
        do
        begin
            @(negedge clk);
            taken = !coeff_stall;
            @(posedge clk);
        end
        while (!taken);
        predict_codes(c, eob);
    endtask

    // Coefficient mix: mostly zeros and small values, some full range.
    function automatic logic [15:0] rand_coeff();
        logic [15:0] v;
        case ($urandom_range(9)) inside
            [0:3]:   v = '0;
            [4:6]:   v = 16'($urandom_range(1, 4));
            [7:8]:   v = 16'($urandom_range(1, 255));
            default: v = 16'($urandom);
        endcase
        if ($urandom_range(1) == 1)
        begin
            v = -v;
        end
        return v;
    endfunction

    function automatic logic [15:0] rand_nonzero();
        logic [15:0] v;
        do
        begin
            v = rand_coeff();
        end
        while (v == 16'd0);
        return v;
    endfunction

    // Largest and smallest values, unit values, and a closing zero run.
    task automatic test_extreme_values();
        send_coeff(16'h7FFF, 1'b0);
        send_coeff(16'h8000, 1'b0);
        send_coeff(16'h0000, 1'b0);
        send_coeff(16'h0000, 1'b0);
        send_coeff(16'h0001, 1'b0);
        send_coeff(16'hFFFF, 1'b0);
        send_coeff(16'h0000, 1'b1);
    endtask

    // Blocks of zeros only leave the sign buffer empty.
    task automatic test_empty_sign_buffer();
        send_coeff(16'h0000, 1'b1);
        send_coeff(16'h0000, 1'b0);
        send_coeff(16'h0000, 1'b0);
        send_coeff(16'h0000, 1'b1);
    endtask

    // A nonzero closing coefficient is not followed by a run code.
    task automatic test_closing_nonzero();
        send_coeff(16'h0001, 1'b1);
        send_coeff(16'h0000, 1'b0);
        send_coeff(16'h0000, 1'b0);
        send_coeff(16'hFFF9, 1'b1);
        send_coeff(16'h0003, 1'b0);
        send_coeff(16'hFFFE, 1'b1);
    endtask

    // Random blocks, with some overlong ones that fill the sign buffer or the run count.
    task automatic test_random_blocks();
        int blk;
        int kind;
        int len;
        int sent;
        sent = 0;
        blk  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            kind = (blk < 2) ? blk : $urandom_range(9);
            // A few blocks early on run with no idling on either side.
            gap_pct = (blk >= 3 && blk < 7) ? 0 : IDLE_PCT;
            case (kind)
                0:
                begin
                    len = $urandom_range(BLOCK_SIZE + 1, BLOCK_SIZE + 8);
                    for (int i = 0; i < len; i++)
                    begin
                        send_coeff(rand_nonzero(), i == len - 1);
                    end
                end
                1:
                begin
                    len = $urandom_range(BLOCK_SIZE + 1, BLOCK_SIZE + 6);
                    for (int i = 0; i < len - 1; i++)
                    begin
                        send_coeff(16'h0000, 1'b0);
                    end
                    send_coeff(rand_coeff(), 1'b1);
                end
                default:
                begin
                    len = $urandom_range(1, BLOCK_SIZE);
                    for (int i = 0; i < len; i++)
                    begin
                        send_coeff(rand_coeff(), i == len - 1);
                    end
                end
            endcase
            sent += len;
            blk++;
        end
        gap_pct = IDLE_PCT;
    endtask

    // Receiver stalls at random on its own schedule.
    always @(posedge clk)
    begin
        code_stall <= ($urandom_range(99) < gap_pct);
    end

    // Each code beat is compared with the oldest expected codeword.
    always @(negedge clk)
    begin
        zrcoef_pkg::result_t want;
        if (rst_n && code_valid && !code_stall)
        begin
            if (expected_codes.size() == 0)
            begin
                $error("unexpected code beat: code_bits %h code_length %0d block_done %b",
                       code_bits, code_length, block_done);
                err_count++;
            end
            else
            begin
                want = expected_codes.pop_front();
                if (code_bits !== want.bits)
                begin
                    $error("code_bits: expected %h, actual %h", want.bits, code_bits);
                    err_count++;
                end
                if (code_length !== want.length)
                begin
                    $error("code_length: expected %0d, actual %0d", want.length, code_length);
                    err_count++;
                end
                if (block_done !== want.done)
                begin
                    $error("block_done: expected %b, actual %b", want.done, block_done);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        gap_pct   = IDLE_PCT;
        run_len   = '0;
        sign_buf  = '0;
        sign_cnt  = '0;
        rst_n        <= 1'b0;
        coeff_valid  <= 1'b0;
        coefficient  <= '0;
        end_of_block <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_values();
        test_empty_sign_buffer();
        test_closing_nonzero();
        test_random_blocks();

        // Drain the output side, then watch for stray beats.
        coeff_valid <= 1'b0;
        while (expected_codes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
